// ===== rtl/route_table_longest_prefix_unit_macros.svh =====
// Assertion macros for the route table RTL file.
`ifndef ROUTE_TABLE_LONGEST_PREFIX_UNIT_MACROS_SVH
`define ROUTE_TABLE_LONGEST_PREFIX_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define RT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/rtlpm_pkg.sv =====
`timescale 1ns / 1ps
package rtlpm_pkg;
	localparam int TableDepth = 32;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int InterfaceCount = 16;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0, CMD_INV_IF = 3'd1, CMD_INV_NET = 3'd2,
		CMD_LOOKUP = 3'd3, CMD_TICK = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_NO_ROUTE = 2'd1, ST_FULL = 2'd2, ST_MCAST = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_WAIT, S_APPEND, S_DONE
	} state_t;

	localparam logic CFG_GARBAGE = 1'b0;
	localparam logic CFG_METRIC = 1'b1;

	typedef struct packed {
		logic [31:0] network;
		logic [5:0] prefix;
		logic [31:0] gateway;
		logic [3:0] ifc;
		logic valid;
		logic [7:0] metric;
		logic [15:0] countdown;
	} entry_t;

	function automatic logic [31:0] mask_of(input logic [5:0] len);
		logic [31:0] m;
		m = (len == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - len));
		return m;
	endfunction
endpackage

// ===== rtl/rtlpm_ram.sv =====
`timescale 1ns / 1ps
module rtlpm_ram #(
	parameter int Depth = 32,
	parameter int Width = 8
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/route_table_longest_prefix_unit.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Transfer content
// s_axis    | in        | one command with its operands
// m_axis    | out       | one status and route result per command
// cfg       | in        | register index and write data
//
// Every command walks the stored entries once, one read a cycle from the table
// memory, then passes through WAIT (and APPEND for an add) to DONE, where its
// result is loaded once the output is free; IDLE then takes the next command.
// Add and tick compact the table in place as they walk (the write pointer never
// passes the read pointer). Reset clears the fill count and the controller and
// restores the config registers, not the table. A stalled result holds the next
// command in its last step until the output is free; it is taken and walked.
`include "route_table_longest_prefix_unit_macros.svh"
module route_table_longest_prefix_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// lsb up: command[2:0], network_address[34:3], prefix_length[40:35],
	// gateway_address[72:41], interface_index[76:73], destination_address[108:77],
	// filter_enable[109], zero fill to 112
	input  logic [111:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// lsb up: status[1:0], route_destination[33:2], route_prefix_length[39:34],
	// route_gateway[71:40], route_interface[75:72], route_metric[83:76], zero to 88
	output logic [87:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int IW = rtlpm_pkg::IdxW;
	localparam int CW = rtlpm_pkg::CntW;
	localparam int EW = $bits(rtlpm_pkg::entry_t);

	rtlpm_pkg::state_t state_q, state_d;
	logic [15:0] garbage_q;
	logic [7:0] metric_cfg_q;
	logic [CW-1:0] used_q, rd_q, wr_q;
	logic [2:0] cmd_q;
	logic [31:0] net_q, gw_q, dst_q;
	logic [5:0] plen_q;
	logic [3:0] ifc_q;
	logic filt_q;
	logic found_q;
	rtlpm_pkg::entry_t best_q;
	logic [5:0] bestlen_q;
	logic rvalid_s1;
	logic [CW-1:0] ridx_s1;
	logic out_valid_q;
	logic [87:0] out_data_q;

	logic ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	rtlpm_pkg::entry_t ram_wdata, ram_rdata;
	logic [EW-1:0] ram_rbits;

	assign ram_rdata = rtlpm_pkg::entry_t'(ram_rbits);

	rtlpm_ram #(.Depth(rtlpm_pkg::TableDepth), .Width(EW)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rbits)
	);

	// The output register can take a new result when it is empty or being drained.
	logic accept_in, out_free;
	assign s_axis_tready = (state_q == rtlpm_pkg::S_IDLE);
	assign accept_in = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// Per-entry processing of the entry read in the previous cycle.
	rtlpm_pkg::entry_t e, e_mod;
	logic keep, inv_hit, match;
	logic [5:0] elen;
	logic [31:0] emask, nmask;
	logic [15:0] gdelay;

	always_comb begin
		e = ram_rdata;
		e_mod = e;
		keep = 1'b1;
		inv_hit = 1'b0;
		elen = (e.prefix > 6'd32) ? 6'd32 : e.prefix;
		emask = rtlpm_pkg::mask_of(elen);
		nmask = rtlpm_pkg::mask_of(plen_q);
		gdelay = (garbage_q == 16'd0) ? 16'd1 : garbage_q;
		match = e.valid && ((dst_q & emask) == (e.network & emask))
			&& (!filt_q || e.ifc == ifc_q) && (!found_q || elen >= bestlen_q);
		case (rtlpm_pkg::cmd_t'(cmd_q))
			rtlpm_pkg::CMD_ADD: keep = (e.network != net_q);
			rtlpm_pkg::CMD_INV_IF: inv_hit = (e.ifc == ifc_q);
			rtlpm_pkg::CMD_INV_NET: inv_hit = (e.ifc == ifc_q) && (e.prefix < 6'd32)
				&& (e.prefix == plen_q) && (e.network == (net_q & nmask));
			rtlpm_pkg::CMD_TICK: begin
				if (!e.valid) begin
					if (e.countdown <= 16'd1) begin
						keep = 1'b0;
					end else begin
						e_mod.countdown = e.countdown - 16'd1;
					end
				end
			end
			default: ;
		endcase
		if (inv_hit) begin
			e_mod.valid = 1'b0;
			e_mod.metric = metric_cfg_q;
			e_mod.countdown = gdelay;
		end
	end

	logic is_write_cmd, is_lookup, mcast, ifc_ok;
	assign is_lookup = (cmd_q == rtlpm_pkg::CMD_LOOKUP);
	assign is_write_cmd = (cmd_q <= rtlpm_pkg::CMD_INV_NET) || (cmd_q == rtlpm_pkg::CMD_TICK);
	assign mcast = (dst_q[31:8] == 24'hE00000);
	assign ifc_ok = (32'(ifc_q) < rtlpm_pkg::InterfaceCount);

	always_comb begin
		ram_raddr = rd_q[IW-1:0];
		ram_we = 1'b0;
		ram_waddr = wr_q[IW-1:0];
		ram_wdata = e_mod;
		if (state_q == rtlpm_pkg::S_SCAN || state_q == rtlpm_pkg::S_WAIT) begin
			ram_we = rvalid_s1 && is_write_cmd && keep;
		end else if (state_q == rtlpm_pkg::S_APPEND) begin
			ram_we = (wr_q < CW'(rtlpm_pkg::TableDepth));
			ram_wdata = '{network: net_q, prefix: plen_q, gateway: gw_q, ifc: ifc_q,
				valid: 1'b1, metric: 8'd1, countdown: 16'd0};
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtlpm_pkg::S_IDLE: if (accept_in) state_d = rtlpm_pkg::S_SCAN;
			rtlpm_pkg::S_SCAN: if (rd_q >= used_q) state_d = rtlpm_pkg::S_WAIT;
			rtlpm_pkg::S_WAIT:
				state_d = (cmd_q == rtlpm_pkg::CMD_ADD && ifc_ok)
					? rtlpm_pkg::S_APPEND : rtlpm_pkg::S_DONE;
			rtlpm_pkg::S_APPEND: state_d = rtlpm_pkg::S_DONE;
			rtlpm_pkg::S_DONE: if (out_free) state_d = rtlpm_pkg::S_IDLE;
			default: state_d = rtlpm_pkg::S_IDLE;
		endcase
	end

	logic [87:0] result;
	always_comb begin
		result = '0;
		if (is_lookup) begin
			if (mcast) begin
				if (filt_q && ifc_ok) begin
					result = {4'd0, 8'd0, ifc_q, 32'd0, 6'd32, dst_q, rtlpm_pkg::ST_OK};
				end else begin
					result[1:0] = rtlpm_pkg::ST_MCAST;
				end
			end else if (!found_q) begin
				result[1:0] = rtlpm_pkg::ST_NO_ROUTE;
			end else begin
				result = {4'd0, best_q.metric, best_q.ifc, best_q.gateway, bestlen_q,
					best_q.network, rtlpm_pkg::ST_OK};
			end
		end else if (cmd_q == rtlpm_pkg::CMD_ADD && ifc_ok
			&& wr_q >= CW'(rtlpm_pkg::TableDepth)) begin
			result[1:0] = rtlpm_pkg::ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtlpm_pkg::S_IDLE;
			used_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			rvalid_s1 <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
			garbage_q <= 16'd120;
			metric_cfg_q <= 8'd16;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rtlpm_pkg::CFG_GARBAGE) garbage_q <= cfg_data;
				else metric_cfg_q <= cfg_data[7:0];
			end
			rvalid_s1 <= (state_q == rtlpm_pkg::S_SCAN) && (rd_q < used_q);
			ridx_s1 <= rd_q;
			if (state_q == rtlpm_pkg::S_SCAN && rd_q < used_q) rd_q <= rd_q + 1'b1;
			if (accept_in) begin
				rd_q <= '0;
				wr_q <= '0;
				found_q <= 1'b0;
			end
			if (rvalid_s1) begin
				if (is_write_cmd && keep) wr_q <= wr_q + 1'b1;
				if (is_lookup && match) begin
					found_q <= 1'b1;
					best_q <= e;
					bestlen_q <= elen;
				end
			end
			if (state_q == rtlpm_pkg::S_WAIT && is_write_cmd) used_q <= wr_q;
			if (state_q == rtlpm_pkg::S_APPEND && wr_q < CW'(rtlpm_pkg::TableDepth))
				used_q <= wr_q + 1'b1;
			if (state_q == rtlpm_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				out_data_q <= result;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			cmd_q <= s_axis_tdata[2:0];
			net_q <= s_axis_tdata[34:3];
			plen_q <= (s_axis_tdata[40:35] > 6'd32) ? 6'd32 : s_axis_tdata[40:35];
			gw_q <= s_axis_tdata[72:41];
			ifc_q <= s_axis_tdata[76:73];
			dst_q <= s_axis_tdata[108:77];
			filt_q <= s_axis_tdata[109];
		end
	end

	`RT_ASSERT_IMPL(a_used_bound, clk, arst_n, 1'b1,
		used_q <= CW'(rtlpm_pkg::TableDepth), "fill count beyond depth")
	`RT_ASSERT_IMPL(a_wr_behind_rd, clk, arst_n, ram_we && state_q == rtlpm_pkg::S_SCAN,
		wr_q <= ridx_s1, "compaction write passed read")
	`RT_ASSERT_NEXT(a_done_out, clk, arst_n, state_q == rtlpm_pkg::S_DONE,
		out_valid_q, "result not loaded")
endmodule

// ===== tb/route_table_longest_prefix_unit_tb.sv =====
`timescale 1ns / 1ps
module route_table_longest_prefix_unit_tb;
	import rtlpm_pkg::*;

	localparam int TimeoutCycles = 600000;
	localparam int ReportLimit = 10;
	localparam int RandomPerPhase = 160;
	localparam int PhaseCount = 5;
	localparam int PoolSize = 48;
	localparam int HoldOffCycles = 400;

	// One command as it travels on the slave side.
	typedef struct {
		cmd_t cmd;
		logic [31:0] network;
		logic [5:0] prefix;
		logic [31:0] gateway;
		logic [3:0] ifc;
		logic [31:0] dest;
		logic filter;
	} route_cmd_t;

	// One answer as it travels on the master side.
	typedef struct {
		status_t status;
		logic [31:0] dest;
		logic [5:0] prefix;
		logic [31:0] gateway;
		logic [3:0] ifc;
		logic [7:0] metric;
	} route_answer_t;

	// A row of the directed table: when typed is set, the answer written in the
	// row is the expectation; otherwise the route table shadow supplies it.
	typedef struct {
		route_cmd_t item;
		bit typed;
		route_answer_t answer;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [15:0] cfg_data;

	route_table_longest_prefix_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the route table, kept in table order.
	entry_t shadow_table[TableDepth];
	int shadow_used;
	logic [15:0] shadow_garbage_delay;
	logic [7:0] shadow_down_metric;

	route_answer_t pending_answers[$];
	directed_row_t rows[$];
	int mismatch_count;
	int cycle_count;

	// Traffic shaping, changed by the stimulus process at phase boundaries.
	int send_idle_pct;
	int recv_stall_pct;
	logic hold_off_request;
	int hold_off_left;

	logic [31:0] net_pool[PoolSize];
	logic [5:0] prefix_pool[PoolSize];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		if (len == 6'd0)
			return 32'd0;
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	function automatic logic [111:0] pack_cmd(input route_cmd_t c);
		return {2'b00, c.filter, c.dest, c.ifc, c.gateway, c.prefix, c.network, c.cmd};
	endfunction

	function automatic logic [87:0] pack_answer(input route_answer_t a);
		return {4'd0, a.metric, a.ifc, a.gateway, a.prefix, a.dest, a.status};
	endfunction

	function automatic route_answer_t unpack_answer(input logic [87:0] d);
		route_answer_t a;
		a.status = status_t'(d[1:0]);
		a.dest = d[33:2];
		a.prefix = d[39:34];
		a.gateway = d[71:40];
		a.ifc = d[75:72];
		a.metric = d[83:76];
		return a;
	endfunction

	function automatic void put_row(input route_cmd_t item, input bit typed,
			input route_answer_t answer);
		directed_row_t r;
		r.item = item;
		r.typed = typed;
		r.answer = answer;
		rows = {rows, r};
	endfunction

	function automatic void mark_down(input int i);
		shadow_table[i].valid = 1'b0;
		shadow_table[i].metric = shadow_down_metric;
		shadow_table[i].countdown = (shadow_garbage_delay == 16'd0) ? 16'd1 :
			shadow_garbage_delay;
	endfunction

	// Applies one command to the shadow table and returns the answer it earns.
	function automatic route_answer_t route_table_step(input route_cmd_t c);
		route_answer_t a;
		logic [5:0] len;
		logic [31:0] m;
		int w;
		int best;
		bit found;
		bit keep;
		a = '{ST_OK, 32'd0, 6'd0, 32'd0, 4'd0, 8'd0};
		len = (c.prefix > 6'd32) ? 6'd32 : c.prefix;
		m = prefix_mask(len);
		case (c.cmd)
			CMD_ADD: begin
				// Every entry with the same stored network goes first, then the
				// new route is appended if a slot is left.
				w = 0;
				for (int i = 0; i < shadow_used; i++) begin
					if (shadow_table[i].network != c.network) begin
						shadow_table[w] = shadow_table[i];
						w++;
					end
				end
				shadow_used = w;
				if (shadow_used >= TableDepth) begin
					a.status = ST_FULL;
				end else begin
					shadow_table[w] = '{c.network, len, c.gateway, c.ifc, 1'b1, 8'd1, 16'd0};
					shadow_used = w + 1;
				end
			end
			CMD_INV_IF: begin
				for (int i = 0; i < shadow_used; i++)
					if (shadow_table[i].ifc == c.ifc)
						mark_down(i);
			end
			CMD_INV_NET: begin
				// Host routes are never touched by a network invalidation.
				for (int i = 0; i < shadow_used; i++)
					if (shadow_table[i].ifc == c.ifc && shadow_table[i].prefix < 6'd32 &&
							shadow_table[i].prefix == len &&
							shadow_table[i].network == (c.network & m))
						mark_down(i);
			end
			CMD_LOOKUP: begin
				if ((c.dest & 32'hFFFF_FF00) == 32'hE000_0000) begin
					if (!c.filter) begin
						a.status = ST_MCAST;
					end else begin
						a.dest = c.dest;
						a.prefix = 6'd32;
						a.ifc = c.ifc;
					end
				end else begin
					found = 1'b0;
					best = 0;
					for (int i = 0; i < shadow_used; i++) begin
						m = prefix_mask(shadow_table[i].prefix);
						if (!shadow_table[i].valid) continue;
						if ((c.dest & m) != (shadow_table[i].network & m)) continue;
						if (c.filter && shadow_table[i].ifc != c.ifc) continue;
						// Ties go to the later entry, so only a shorter prefix loses.
						if (found && shadow_table[i].prefix < shadow_table[best].prefix)
							continue;
						found = 1'b1;
						best = i;
					end
					if (!found) begin
						a.status = ST_NO_ROUTE;
					end else begin
						a.dest = shadow_table[best].network;
						a.prefix = shadow_table[best].prefix;
						a.gateway = shadow_table[best].gateway;
						a.ifc = shadow_table[best].ifc;
						a.metric = shadow_table[best].metric;
					end
				end
			end
			CMD_TICK: begin
				w = 0;
				for (int i = 0; i < shadow_used; i++) begin
					keep = 1'b1;
					if (!shadow_table[i].valid) begin
						if (shadow_table[i].countdown <= 16'd1)
							keep = 1'b0;
						else
							shadow_table[i].countdown = shadow_table[i].countdown - 16'd1;
					end
					if (keep) begin
						shadow_table[w] = shadow_table[i];
						w++;
					end
				end
				shadow_used = w;
			end
			default: ;
		endcase
		return a;
	endfunction

	// Offers one command and waits for its transfer. This task lowers the valid
	// line only when the sender decides to idle, so back-to-back items keep it high.
	task automatic send_cmd(input route_cmd_t c, input bit typed, input route_answer_t a);
		route_answer_t predicted;
		route_answer_t expected;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_cmd(c);
		do @(posedge clk); while (!s_axis_tready);
		predicted = route_table_step(c);
		expected = typed ? a : predicted;
		pending_answers = {pending_answers, expected};
	endtask

	task automatic write_register(input logic index, input logic [15:0] value);
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == CFG_GARBAGE)
			shadow_garbage_delay = value;
		else
			shadow_down_metric = value[7:0];
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Random commands lean on a small pool of networks so that adds replace
	// entries, lookups hit, and network invalidations find their target.
	function automatic route_cmd_t random_cmd();
		route_cmd_t c;
		int pick;
		int k;
		k = $urandom_range(PoolSize - 1);
		pick = $urandom_range(99);
		c.network = ($urandom_range(9) == 0) ? $urandom : net_pool[k];
		c.prefix = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : prefix_pool[k];
		c.gateway = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
		c.ifc = ($urandom_range(1) == 0) ? 4'(k % 6) : 4'($urandom_range(15));
		c.filter = $urandom_range(1);
		case ($urandom_range(5))
			0: c.dest = $urandom;
			1: c.dest = 32'hE000_0000 | $urandom_range(255);
			default: c.dest = net_pool[k] ^ ($urandom & ~prefix_mask(6'($urandom_range(32))));
		endcase
		if (pick < 32)
			c.cmd = CMD_ADD;
		else if (pick < 40)
			c.cmd = CMD_INV_IF;
		else if (pick < 50)
			c.cmd = CMD_INV_NET;
		else if (pick < 88)
			c.cmd = CMD_LOOKUP;
		else
			c.cmd = CMD_TICK;
		return c;
	endfunction

	function automatic route_cmd_t make_cmd(input cmd_t cmd, input logic [31:0] network,
			input logic [5:0] prefix, input logic [31:0] gateway, input logic [3:0] ifc,
			input logic [31:0] dest, input logic filter);
		route_cmd_t c;
		c = '{cmd, network, prefix, gateway, ifc, dest, filter};
		return c;
	endfunction

	// Result side: checks every transfer and decides the stall for the next edge.
	always @(posedge clk or negedge arst_n) begin
		route_answer_t got;
		route_answer_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_off_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = unpack_answer(m_axis_tdata);
				if (pending_answers.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= ReportLimit)
						$display("ERROR: result transfer with nothing expected: %h", m_axis_tdata);
				end else begin
					want = pending_answers.pop_front();
					if (m_axis_tdata != pack_answer(want)) begin
						mismatch_count++;
						if (mismatch_count <= ReportLimit)
							$display({"ERROR: expected st=%0d dst=%h len=%0d gw=%h if=%0d met=%0d,",
								" got st=%0d dst=%h len=%0d gw=%h if=%0d met=%0d"},
								want.status, want.dest, want.prefix, want.gateway, want.ifc,
								want.metric, got.status, got.dest, got.prefix, got.gateway,
								got.ifc, got.metric);
					end
				end
			end
			// A hold-off request starts a long stall that fills the block up.
			if (hold_off_request && hold_off_left == 0) begin
				hold_off_left <= HoldOffCycles;
				m_axis_tready <= 1'b0;
			end else if (hold_off_left > 1) begin
				hold_off_left <= hold_off_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				if (hold_off_left == 1)
					hold_off_left <= -1;
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TimeoutCycles) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		route_answer_t none;
		route_answer_t typed_ans;
		logic [15:0] delay_set[PhaseCount];
		logic [7:0] metric_set[PhaseCount];
		int idle_set[PhaseCount];
		int stall_set[PhaseCount];
		delay_set = '{16'd120, 16'd1, 16'd65535, 16'd3, 16'd2};
		metric_set = '{8'd16, 8'd255, 8'd1, 8'd200, 8'd7};
		idle_set = '{0, 57, 0, 18, 0};
		stall_set = '{0, 0, 57, 18, 0};
		none = '{ST_OK, 32'd0, 6'd0, 32'd0, 4'd0, 8'd0};

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_GARBAGE;
		cfg_data = '0;
		hold_off_request = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		shadow_used = 0;
		shadow_garbage_delay = 16'd120;
		shadow_down_metric = 8'd16;
		for (int i = 0; i < PoolSize; i++) begin
			prefix_pool[i] = 6'($urandom_range(32));
			net_pool[i] = $urandom & prefix_mask(prefix_pool[i]);
			// A few pool networks keep host bits set, since the table stores them as given.
			if (i % 7 == 0)
				net_pool[i] = $urandom;
			if ((net_pool[i] & 32'hFFFF_FF00) == 32'hE000_0000)
				net_pool[i] = ~net_pool[i];
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, multicast, extremes of every field, replace,
		// later-entry tie break, both invalidations, and a tick on invalidated entries.
		typed_ans = none;
		typed_ans.status = ST_NO_ROUTE;
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'h0A00_0001, 0), 1, typed_ans);
		typed_ans.status = ST_MCAST;
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 4'd3, 32'hE000_0005, 0), 1, typed_ans);
		typed_ans = '{ST_OK, 32'hE000_00FF, 6'd32, 32'd0, 4'd15, 8'd0};
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 4'd15, 32'hE000_00FF, 1), 1, typed_ans);
		put_row(make_cmd(CMD_ADD, 32'd0, 6'd0, 32'hFFFF_FFFF, 4'd0, 0, 0), 1, none);
		put_row(make_cmd(CMD_ADD, 32'hFFFF_FFFF, 6'd32, 0, 4'd15, 0, 0), 1, none);
		put_row(make_cmd(CMD_ADD, 32'h0A01_0000, 6'd63, 1, 4'd3, 0, 0), 1, none);
		put_row(make_cmd(CMD_ADD, 32'h0A01_0000, 6'd16, 2, 4'd5, 0, 0), 1, none);
		put_row(make_cmd(CMD_ADD, 32'h0A01_0200, 6'd24, 3, 4'd5, 0, 0), 1, none);
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'h0A01_0203, 0), 0, none);
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'h0A01_0203, 1), 0, none);
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFFF, 0), 0, none);
		put_row(make_cmd(CMD_ADD, 32'h0A01_0280, 6'd24, 4, 4'd7, 0, 0), 1, none);
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'h0A01_0203, 0), 0, none);
		put_row(make_cmd(CMD_INV_NET, 32'h0A01_024D, 6'd24, 0, 4'd5, 0, 0), 1, none);
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 4'd5, 32'h0A01_0203, 1), 0, none);
		put_row(make_cmd(CMD_INV_IF, 0, 0, 0, 4'd7, 0, 0), 1, none);
		put_row(make_cmd(CMD_INV_IF, 0, 0, 0, 4'd7, 0, 0), 1, none);
		put_row(make_cmd(CMD_INV_NET, 32'hFFFF_FFFF, 6'd32, 0, 4'd15, 0, 0), 1, none);
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'hE000_0100, 0), 0, none);
		put_row(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0), 1, none);
		put_row(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'h0A01_0203, 0), 0, none);
		foreach (rows[i])
			send_cmd(rows[i].item, rows[i].typed, rows[i].answer);
		wait_drained();

		// Random phases, each with its own register setting and traffic shape.
		for (int p = 0; p < PhaseCount; p++) begin
			write_register(CFG_GARBAGE, delay_set[p]);
			write_register(CFG_METRIC, {8'd0, metric_set[p]});
			send_idle_pct = idle_set[p];
			recv_stall_pct = stall_set[p];
			if (p == PhaseCount - 1) begin
				// Fill the table past its depth while the result side holds off.
				hold_off_request <= 1'b1;
				for (int k = 0; k < 36; k++)
					send_cmd(make_cmd(CMD_ADD, net_pool[k], prefix_pool[k], $urandom,
						4'(k % 16), 0, 0), 0, none);
				hold_off_request <= 1'b0;
			end
			for (int n = 0; n < RandomPerPhase; n++)
				send_cmd(random_cmd(), 0, none);
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
